// ===== rtl/pif_pkg.sv =====
package pif_pkg;

  localparam int unsigned MaxWidth = 63;
  localparam int unsigned WidthW   = 6;
  localparam int unsigned NumDigs  = 10;
  localparam int unsigned DigIdxW  = 4;
  localparam int unsigned CharW    = 8;
  localparam int unsigned ArgW     = 32;

  localparam logic [CharW-1:0] ChNul     = 8'h00;
  localparam logic [CharW-1:0] ChPercent = 8'h25;
  localparam logic [CharW-1:0] ChZero    = 8'h30;
  localparam logic [CharW-1:0] ChNine    = 8'h39;
  localparam logic [CharW-1:0] ChSpace   = 8'h20;
  localparam logic [CharW-1:0] ChMinus   = 8'h2d;
  localparam logic [CharW-1:0] ChUpperA  = 8'h41;
  localparam logic [CharW-1:0] ChLowerA  = 8'h61;
  localparam logic [CharW-1:0] ChU       = 8'h75;
  localparam logic [CharW-1:0] ChD       = 8'h64;
  localparam logic [CharW-1:0] ChXl      = 8'h78;
  localparam logic [CharW-1:0] ChXu      = 8'h58;
  localparam logic [CharW-1:0] ChC       = 8'h63;

  // reciprocal of ten, exact for 32-bit operands with a 35-bit shift
  localparam logic [ArgW-1:0] RecipTen = 32'hcccccccd;
  localparam int unsigned RecipShift = 35;

  typedef enum logic [3:0] {
    ModeText  = 4'b0001,
    ModeSpec  = 4'b0010,
    ModeWidth = 4'b0100,
    ModeWait  = 4'b1000
  } mode_e;

  typedef enum logic [2:0] {
    KindNone = 3'd0,
    KindU    = 3'd1,
    KindD    = 3'd2,
    KindXl   = 3'd3,
    KindXu   = 3'd4,
    KindC    = 3'd5
  } kind_e;

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StOne   = 7'b0000010,
    StConv  = 7'b0000100,
    StSize  = 7'b0001000,
    StPad   = 7'b0010000,
    StSign  = 7'b0100000,
    StDigit = 7'b1000000
  } state_e;

  typedef enum logic [1:0] {
    ActNone = 2'd0,
    ActOne  = 2'd1,
    ActNum  = 2'd2
  } act_e;

  typedef enum logic [2:0] {
    EmitNone  = 3'd0,
    EmitOne   = 3'd1,
    EmitPad   = 3'd2,
    EmitSign  = 3'd3,
    EmitDigit = 3'd4
  } emit_e;

  typedef struct packed {
    logic  accept;
    logic  conv_step;
    logic  size;
    logic  pad_step;
    emit_e emit;
  } pif_cmd_t;

  typedef struct packed {
    act_e action;
    logic conv_done;
    logic pad_zero;
    logic neg;
    logic last_digit;
  } pif_status_t;

endpackage

// ===== rtl/pif_ctrl.sv =====
module pif_ctrl import pif_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  pif_status_t status_i,
  output pif_cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   can_load;

  assign can_load    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d          = state_q;
    cmd_o.accept     = 1'b0;
    cmd_o.conv_step  = 1'b0;
    cmd_o.size       = 1'b0;
    cmd_o.pad_step   = 1'b0;
    cmd_o.emit       = EmitNone;
    in_ready_o       = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          unique case (status_i.action)
            ActOne:  state_d = StOne;
            ActNum:  state_d = StConv;
            default: state_d = StIdle;
          endcase
        end
      end
      StOne: begin
        if (can_load) begin
          cmd_o.emit = EmitOne;
          state_d    = StIdle;
        end
      end
      StConv: begin
        cmd_o.conv_step = 1'b1;
        if (status_i.conv_done) state_d = StSize;
      end
      StSize: begin
        cmd_o.size = 1'b1;
        state_d    = StPad;
      end
      StPad: begin
        if (status_i.pad_zero) begin
          state_d = status_i.neg ? StSign : StDigit;
        end else if (can_load) begin
          cmd_o.emit     = EmitPad;
          cmd_o.pad_step = 1'b1;
        end
      end
      StSign: begin
        if (can_load) begin
          cmd_o.emit = EmitSign;
          state_d    = StDigit;
        end
      end
      StDigit: begin
        if (can_load) begin
          cmd_o.emit = EmitDigit;
          if (status_i.last_digit) state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    if (cmd_o.emit != EmitNone) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/pif_dp.sv =====
module pif_dp import pif_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_i,
  input  logic [CharW-1:0]  fmt_char_i,
  input  logic [ArgW-1:0]   arg_value_i,
  input  pif_cmd_t          cmd_in_i,
  output pif_status_t       status_o,
  output logic [CharW-1:0]  out_char_o,
  output logic              last_o
);

  mode_e             mode_q, mode_d;
  kind_e             kind_q, kind_d;
  logic              zero_pad_q, zero_pad_d;
  logic [WidthW-1:0] width_q, width_d;
  act_e              action;
  logic [CharW-1:0]  char_q, char_d;

  logic [ArgW-1:0]    v_q;
  logic               neg_q, hex_q, upper_q;
  logic [3:0]         digs_q [NumDigs];
  logic [DigIdxW-1:0] k_q;
  logic [WidthW-1:0]  pad_q;
  logic [CharW-1:0]   out_char_q;
  logic               last_q;

  logic [WidthW+3:0]  wsum;
  logic [2*ArgW-1:0]  prod;
  logic [ArgW-1:0]    quot;
  logic [3:0]         q10_lo;
  logic [3:0]         digit;
  logic [WidthW-1:0]  len;
  logic [DigIdxW-1:0] k_dec;
  logic [3:0]         cur_dig;
  logic [CharW-1:0]   dig_char;
  logic               is_digit;
  kind_e              kind_new;
  mode_e              mode_eff;

  // parser
  always_comb begin
    unique case (fmt_char_i)
      ChU:     kind_new = KindU;
      ChD:     kind_new = KindD;
      ChXl:    kind_new = KindXl;
      ChXu:    kind_new = KindXu;
      ChC:     kind_new = KindC;
      default: kind_new = KindNone;
    endcase
  end

  assign is_digit = (fmt_char_i >= ChZero) && (fmt_char_i <= ChNine);
  assign wsum = {1'b0, width_q, 3'b000} + {3'b000, width_q, 1'b0}
              + {6'd0, fmt_char_i[3:0]};

  always_comb begin
    mode_d     = mode_q;
    kind_d     = kind_q;
    zero_pad_d = zero_pad_q;
    width_d    = width_q;
    char_d     = fmt_char_i;
    action     = ActNone;
    mode_eff   = mode_q;
    if (!cmd_i) begin
      // a format character cancels a pending conversion
      if (mode_q == ModeWait) begin
        mode_eff = ModeText;
        kind_d   = KindNone;
        mode_d   = ModeText;
      end
      if (mode_eff == ModeText) begin
        if (fmt_char_i == ChPercent) begin
          mode_d     = ModeSpec;
          zero_pad_d = 1'b0;
          width_d    = '0;
        end else if (fmt_char_i != ChNul) begin
          action = ActOne;
        end
      end else if (mode_eff == ModeSpec && fmt_char_i == ChZero) begin
        zero_pad_d = 1'b1;
        mode_d     = ModeWidth;
      end else if (is_digit) begin
        width_d = (wsum > (WidthW+4)'(MaxWidth)) ? WidthW'(MaxWidth) : wsum[WidthW-1:0];
        mode_d  = ModeWidth;
      end else if (kind_new != KindNone) begin
        kind_d = kind_new;
        mode_d = ModeWait;
      end else begin
        if (fmt_char_i == ChPercent) action = ActOne;
        mode_d = ModeText;
      end
    end else if (mode_q == ModeWait) begin
      char_d = arg_value_i[CharW-1:0];
      action = (kind_q == KindC) ? ActOne : ActNum;
      kind_d = KindNone;
      mode_d = ModeText;
    end
  end

  // one digit per step: reciprocal multiply for decimal, nibble for hex
  assign prod   = {{ArgW{1'b0}}, v_q} * {{ArgW{1'b0}}, RecipTen};
  assign q10_lo = {prod[RecipShift+0], 3'b000} + {prod[RecipShift+2:RecipShift], 1'b0};
  always_comb begin
    if (hex_q) begin
      quot  = {4'b0000, v_q[ArgW-1:4]};
      digit = v_q[3:0];
    end else begin
      quot  = ArgW'(prod[2*ArgW-1:RecipShift]);
      digit = v_q[3:0] - q10_lo;
    end
  end

  assign len      = WidthW'(k_q) + WidthW'(neg_q);
  assign k_dec    = k_q - 1'b1;
  assign cur_dig  = digs_q[k_dec];
  assign dig_char = (cur_dig < 4'd10) ? ChZero + CharW'(cur_dig)
                  : (upper_q ? ChUpperA : ChLowerA) + CharW'(cur_dig - 4'd10);

  assign status_o.action     = action;
  assign status_o.conv_done  = (quot == '0);
  assign status_o.pad_zero   = (pad_q == '0);
  assign status_o.neg        = neg_q;
  assign status_o.last_digit = (k_q == DigIdxW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= ModeText;
      kind_q     <= KindNone;
      zero_pad_q <= 1'b0;
      width_q    <= '0;
    end else if (cmd_in_i.accept) begin
      mode_q     <= mode_d;
      kind_q     <= kind_d;
      zero_pad_q <= zero_pad_d;
      width_q    <= width_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_in_i.accept) begin
      char_q  <= char_d;
      neg_q   <= (kind_q == KindD) && arg_value_i[ArgW-1];
      v_q     <= ((kind_q == KindD) && arg_value_i[ArgW-1]) ? (~arg_value_i + 1'b1)
                                                             : arg_value_i;
      hex_q   <= (kind_q == KindXl) || (kind_q == KindXu);
      upper_q <= (kind_q == KindXu);
      k_q     <= '0;
    end else if (cmd_in_i.conv_step) begin
      digs_q[k_q] <= digit;
      k_q         <= k_q + 1'b1;
      v_q         <= quot;
    end else if (cmd_in_i.emit == EmitDigit) begin
      k_q <= k_dec;
    end
    if (cmd_in_i.size) begin
      pad_q <= (width_q > len) ? width_q - len : '0;
    end else if (cmd_in_i.pad_step) begin
      pad_q <= pad_q - 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    unique case (cmd_in_i.emit)
      EmitOne: begin
        out_char_q <= char_q;
        last_q     <= 1'b1;
      end
      EmitPad: begin
        out_char_q <= zero_pad_q ? ChZero : ChSpace;
        last_q     <= 1'b0;
      end
      EmitSign: begin
        out_char_q <= ChMinus;
        last_q     <= 1'b0;
      end
      EmitDigit: begin
        out_char_q <= dig_char;
        last_q     <= (k_q == DigIdxW'(1));
      end
      default: ;
    endcase
  end

  assign out_char_o = out_char_q;
  assign last_o     = last_q;

endmodule

// ===== rtl/printf_integer_formatter.sv =====
// Integer formatter for a printf-like stream. Format characters (cmd 0) are echoed or
// parsed as %[0][width] followed by u, d, x, X, c or %; a u, d, x, X or c spec then
// consumes the next argument word (cmd 1). A c spec prints its low byte unpadded; a number
// is printed padded on the left to the width. One item is worked on at a time. A format
// character is accepted and then its output character, if it has one, is emitted; a c
// conversion likewise. A number is accepted, then runs the conversion loop one digit per
// step (up to 10 decimal or 8 hex digits, one reciprocal multiply per decimal digit), is
// sized, then emits its characters one by one, up to 63 characters, holding while the
// output is not taken. The output register lets the next item be accepted while the final
// character of the previous one waits to be taken.
module printf_integer_formatter import pif_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              cmd_i,
  input  logic [CharW-1:0]  fmt_char_i,
  input  logic [ArgW-1:0]   arg_value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CharW-1:0]  out_char_o,
  output logic              last_o
);

  pif_cmd_t    cmd;
  pif_status_t status;

  pif_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pif_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .fmt_char_i  (fmt_char_i),
    .arg_value_i (arg_value_i),
    .cmd_in_i    (cmd),
    .status_o    (status),
    .out_char_o  (out_char_o),
    .last_o      (last_o)
  );

endmodule

// ===== tb/pif_char_checker.sv =====
module pif_char_checker import pif_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic             cmd_i,
  input  logic [CharW-1:0] fmt_char_i,
  input  logic [ArgW-1:0]  arg_value_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic [CharW-1:0] out_char_i,
  input  logic             last_i,
  output int               mismatch_count_o,
  output int               chars_owed_o
);

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             last;
  } out_char_t;

  mode_e             mode_q;
  logic              zero_pad_q;
  logic [WidthW-1:0] width_q;
  kind_e             kind_q;
  out_char_t         owed_q[$];
  int                mismatches;

  function automatic kind_e conv_kind(input logic [CharW-1:0] ch);
    case (ch)
      ChU:     return KindU;
      ChD:     return KindD;
      ChXl:    return KindXl;
      ChXu:    return KindXu;
      ChC:     return KindC;
      default: return KindNone;
    endcase
  endfunction

  // updates the parser copy and queues the characters this item produces
  task automatic predict_item(input logic is_arg, input logic [CharW-1:0] ch,
                              input logic [ArgW-1:0] arg);
    logic [CharW-1:0] chars[$];
    logic [CharW-1:0] digs[$];
    logic [ArgW-1:0]  mag;
    logic [CharW-1:0] letter;
    logic             neg;
    int unsigned      base;
    int unsigned      digit;
    int unsigned      len;
    int unsigned      pad;
    int unsigned      w;
    out_char_t        entry;
    if (!is_arg) begin
      // a format character drops a conversion still waiting for its argument
      if (mode_q == ModeWait) begin
        kind_q = KindNone;
        mode_q = ModeText;
      end
      if (mode_q == ModeText) begin
        if (ch == ChPercent) begin
          mode_q     = ModeSpec;
          zero_pad_q = 1'b0;
          width_q    = '0;
        end else if (ch != ChNul) begin
          chars.push_back(ch);
        end
      end else if (mode_q == ModeSpec && ch == ChZero) begin
        zero_pad_q = 1'b1;
        mode_q     = ModeWidth;
      end else if (ch >= ChZero && ch <= ChNine) begin
        w       = width_q * 10 + (ch - ChZero);
        width_q = WidthW'((w > MaxWidth) ? MaxWidth : w);
        mode_q  = ModeWidth;
      end else if (conv_kind(ch) != KindNone) begin
        kind_q = conv_kind(ch);
        mode_q = ModeWait;
      end else begin
        if (ch == ChPercent) chars.push_back(ChPercent);
        mode_q = ModeText;
      end
    end else if (mode_q == ModeWait) begin
      if (kind_q == KindC) begin
        chars.push_back(arg[CharW-1:0]);
      end else begin
        neg    = (kind_q == KindD) && arg[ArgW-1];
        mag    = neg ? (~arg + 1'b1) : arg;
        base   = (kind_q == KindXl || kind_q == KindXu) ? 16 : 10;
        letter = (kind_q == KindXu) ? ChUpperA : ChLowerA;
        do begin
          digit = mag % base;
          digs.push_front((digit < 10) ? CharW'(ChZero + digit) :
                                         CharW'(letter + digit - 10));
          mag = mag / base;
        end while (mag != 0);
        len = digs.size() + (neg ? 1 : 0);
        pad = (width_q > len) ? width_q - len : 0;
        // zero padding goes in front of the sign
        repeat (pad) chars.push_back(zero_pad_q ? ChZero : ChSpace);
        if (neg) chars.push_back(ChMinus);
        foreach (digs[i]) chars.push_back(digs[i]);
      end
      kind_q = KindNone;
      mode_q = ModeText;
    end
    foreach (chars[i]) begin
      if (i < MaxWidth) begin
        entry.ch   = chars[i];
        entry.last = (i == chars.size() - 1);
        owed_q.push_back(entry);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_char_t want;
    if (!rst_ni) begin
      mode_q     = ModeText;
      zero_pad_q = 1'b0;
      width_q    = '0;
      kind_q     = KindNone;
      owed_q.delete();
      mismatches = 0;
    end else begin
      // outputs belong to earlier items, so check before predicting
      if (out_valid_i && out_ready_i) begin
        if (owed_q.size() == 0) begin
          $error("out_char: expected nothing, got %h", out_char_i);
          mismatches++;
        end else begin
          want = owed_q.pop_front();
          if (out_char_i !== want.ch) begin
            $error("out_char: expected %h, got %h", want.ch, out_char_i);
            mismatches++;
          end
          if (last_i !== want.last) begin
            $error("last: expected %b, got %b", want.last, last_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) predict_item(cmd_i, fmt_char_i, arg_value_i);
    end
    mismatch_count_o <= mismatches;
    chars_owed_o     <= owed_q.size();
  end

endmodule

// ===== tb/printf_integer_formatter_test.sv =====
module printf_integer_formatter_test;
  import pif_pkg::*;

  localparam int unsigned ResetCycles = 5;
  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 100;
  localparam int unsigned PhaseItems  = 76;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  logic             cmd       = 1'b0;
  logic [CharW-1:0] fmt_char  = '0;
  logic [ArgW-1:0]  arg_value = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [CharW-1:0] out_char;
  logic             last;

  int               mismatches;
  int               chars_owed;
  int unsigned      send_idle_pct = 0;
  int unsigned      stall_pct     = 0;
  logic             hold_req      = 1'b0;
  int unsigned      quiet_cycles  = 0;

  printf_integer_formatter uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .cmd_i       (cmd),
    .fmt_char_i  (fmt_char),
    .arg_value_i (arg_value),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_char_o  (out_char),
    .last_o      (last)
  );

  pif_char_checker char_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .cmd_i            (cmd),
    .fmt_char_i       (fmt_char),
    .arg_value_i      (arg_value),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_char_i       (out_char),
    .last_i           (last),
    .mismatch_count_o (mismatches),
    .chars_owed_o     (chars_owed)
  );

  always #6 clk = ~clk;

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (HoldCycles) begin
          out_ready <= 1'b0;
          @(posedge clk);
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic is_arg, input logic [CharW-1:0] ch,
                           input logic [ArgW-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= is_arg;
    fmt_char  <= ch;
    arg_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_fmt(input logic [CharW-1:0] ch);
    send_item(1'b0, ch, $urandom);
  endtask

  task automatic send_arg(input logic [ArgW-1:0] value);
    send_item(1'b1, CharW'($urandom_range(255)), value);
  endtask

  task automatic send_fmt_str(input string s);
    for (int i = 0; i < s.len(); i++) send_fmt(s[i]);
  endtask

  function automatic logic [ArgW-1:0] pick_arg();
    case ($urandom_range(6))
      0:       return '0;
      1:       return '1;
      2:       return 32'h8000_0000;
      3:       return 32'h7fff_ffff;
      4:       return $urandom_range(999);
      5:       return -$urandom_range(999, 1);
      default: return $urandom;
    endcase
  endfunction

  // mostly well-formed specs with their argument, mixed with text and stray items
  task automatic run_random(input int unsigned n);
    int unsigned      sent;
    int unsigned      r;
    int unsigned      ndig;
    logic [CharW-1:0] conv;
    logic             needs_arg;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(99);
      if (r < 20) begin
        conv = CharW'($urandom_range(255));
        send_fmt(conv);
        if (conv != ChNul) sent++;
      end else if (r < 24) begin
        send_arg(pick_arg());
      end else begin
        send_fmt(ChPercent);
        sent++;
        if ($urandom_range(1)) begin
          send_fmt(ChZero);
          sent++;
        end
        r    = $urandom_range(19);
        ndig = (r < 8) ? 0 : (r < 17) ? 1 : (r < 19) ? 2 : 3;
        repeat (ndig) begin
          send_fmt(CharW'(ChZero + $urandom_range(9)));
          sent++;
        end
        r         = $urandom_range(99);
        needs_arg = 1'b0;
        if (r < 88) begin
          case ($urandom_range(5))
            0:       conv = ChU;
            1:       conv = ChD;
            2:       conv = ChXl;
            3:       conv = ChXu;
            4:       conv = ChC;
            default: conv = ChPercent;
          endcase
          needs_arg = (conv != ChPercent);
        end else if (r < 94) begin
          conv = CharW'($urandom_range(255));
        end else begin
          conv = ChNul;
        end
        send_fmt(conv);
        sent++;
        if (needs_arg) begin
          r = $urandom_range(99);
          if (r < 85) begin
            send_arg(pick_arg());
            sent++;
          end else if (r < 95) begin
            // format character cancels the conversion; an argument, if one follows, is then stray
            send_fmt(CharW'($urandom_range(255, 1)));
            sent++;
            if (r < 90) send_arg(pick_arg());
          end
        end
      end
    end
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;

    send_fmt(8'hff);
    send_fmt(ChNul);
    send_fmt_str("%%");
    send_fmt_str("%x");
    send_arg('0);
    send_fmt_str("%d");
    send_arg(32'h8000_0000);
    send_fmt_str("%099X");
    send_arg(32'hffff_ffff);
    send_fmt_str("%9c");
    send_arg(32'h1234_5641);
    send_fmt_str("%q");
    send_fmt(ChPercent);
    send_fmt(ChNul);
    send_fmt_str("%u");
    send_fmt(8'hff);
    send_arg(32'h7fff_ffff);

    hold_req = 1'b1;
    run_random(PhaseItems);
    send_idle_pct = 84;
    run_random(PhaseItems);
    send_idle_pct = 0;
    stall_pct     = 84;
    run_random(PhaseItems);
    send_idle_pct = 23;
    stall_pct     = 23;
    run_random(PhaseItems);
    in_valid <= 1'b0;

    @(posedge clk);
    while (chars_owed != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && chars_owed == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
